/* rtl/core/nhpv_pkg.sv */
// Package for the network header parser and validator.
// Holds the parse phase codes, control bit positions, field widths and status codes.
// It has no dependencies.
package nhpv_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned CountW = 3;
  localparam int unsigned LenW   = 5;
  localparam int unsigned StatW  = 2;

  localparam logic [PhaseW-1:0] PhCtl     = 4'd0;
  localparam logic [PhaseW-1:0] PhTtl     = 4'd1;
  localparam logic [PhaseW-1:0] PhSeq     = 4'd2;
  localparam logic [PhaseW-1:0] PhGraph   = 4'd3;
  localparam logic [PhaseW-1:0] PhDst     = 4'd4;
  localparam logic [PhaseW-1:0] PhSrc     = 4'd5;
  localparam logic [PhaseW-1:0] PhPdu     = 4'd6;
  localparam logic [PhaseW-1:0] PhProxy   = 4'd7;
  localparam logic [PhaseW-1:0] PhSecond  = 4'd8;
  localparam logic [PhaseW-1:0] PhFirst   = 4'd9;
  localparam logic [PhaseW-1:0] PhPayload = 4'd10;

  localparam int unsigned DstModeBit = 7;
  localparam int unsigned SrcModeBit = 6;
  localparam int unsigned ProxyBit   = 2;
  localparam int unsigned SecondBit  = 1;
  localparam int unsigned FirstBit   = 0;

  localparam logic [15:0] MaxAgeReset = 16'd1000;

  localparam logic [StatW-1:0] StatAccepted  = 2'd0;
  localparam logic [StatW-1:0] StatTtlZero   = 2'd1;
  localparam logic [StatW-1:0] StatExpired   = 2'd2;
  localparam logic [StatW-1:0] StatTruncated = 2'd3;

endpackage

/* rtl/core/net_header_parser_validator.sv */
// Top level of the network header parser and validator.
// Depends on nhpv_pkg for phase codes, control bit positions and status codes.
//
// The block takes one packet byte per item and may accept an item in every
// cycle. Each byte advances the header parse in the same cycle, and a result
// (header complete or packet truncated) appears in the output register on the
// next cycle. The only hold-off is the output register: a new item is stalled
// while a result waits there and the output side stalls. A packet gives at most
// one result; payload bytes after the header give none.
module net_header_parser_validator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [15:0]                   cfg_max_age_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          start_flag_i,
  input  logic                          end_flag_i,
  input  logic [15:0]                   now_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    control_bits_o,
  output logic [7:0]                    hop_limit_o,
  output logic [15:0]                   sequence_res_o,
  output logic [15:0]                   graph_id_o,
  output logic [63:0]                   dest_addr_o,
  output logic [63:0]                   src_addr_o,
  output logic [7:0]                    pdu_type_o,
  output logic [15:0]                   proxy_addr_o,
  output logic [15:0]                   second_addr_o,
  output logic [15:0]                   first_addr_o,
  output logic [nhpv_pkg::LenW-1:0]     hdr_len_o,
  output logic [nhpv_pkg::StatW-1:0]    status_o
);
  import nhpv_pkg::*;

  logic [15:0]       max_age_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CountW-1:0] fbc_q, fbc_d;
  logic [LenW-1:0]   cons_q, cons_d;
  logic [7:0]        ctl_q, ctl_d;
  logic [7:0]        ttl_q, ttl_d;
  logic [15:0]       seq_q, seq_d;
  logic [15:0]       graph_q, graph_d;
  logic [63:0]       dst_q, dst_d;
  logic [63:0]       src_q, src_d;
  logic [7:0]        pdu_q, pdu_d;
  logic [15:0]       proxy_q, proxy_d;
  logic [15:0]       second_q, second_d;
  logic [15:0]       first_q, first_d;

  logic              out_valid_q;
  logic [7:0]        o_ctl_q, o_ttl_q, o_pdu_q;
  logic [15:0]       o_seq_q, o_graph_q, o_proxy_q, o_second_q, o_first_q;
  logic [63:0]       o_dst_q, o_src_q;
  logic [LenW-1:0]   o_len_q;
  logic [StatW-1:0]  o_stat_q;

  logic              accept;
  logic [PhaseW-1:0] ph_eff;
  logic [CountW-1:0] fbc_eff;
  logic [LenW-1:0]   cons_eff;
  logic              parsing;
  logic [3:0]        fbc_inc;
  logic [3:0]        flen;
  logic              field_done;
  logic [PhaseW-1:0] ph_next;
  logic              complete;
  logic              result;
  logic [StatW-1:0]  res_stat;
  logic [15:0]       age;
  logic [2:0]        lane;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  assign ph_eff   = start_flag_i ? PhCtl : phase_q;
  assign fbc_eff  = start_flag_i ? '0 : fbc_q;
  assign cons_eff = start_flag_i ? '0 : cons_q;
  assign parsing  = (ph_eff < PhPayload);
  assign fbc_inc  = {1'b0, fbc_eff} + 4'd1;
  assign lane     = fbc_eff;

  always_comb begin
    ctl_d    = ctl_q;
    ttl_d    = ttl_q;
    seq_d    = seq_q;
    graph_d  = graph_q;
    dst_d    = dst_q;
    src_d    = src_q;
    pdu_d    = pdu_q;
    proxy_d  = proxy_q;
    second_d = second_q;
    first_d  = first_q;
    if (ph_eff == PhCtl) begin
      ctl_d    = data_byte_i;
      ttl_d    = '0;
      seq_d    = '0;
      graph_d  = '0;
      dst_d    = '0;
      src_d    = '0;
      pdu_d    = '0;
      proxy_d  = '0;
      second_d = '0;
      first_d  = '0;
    end
    case (ph_eff)
      PhTtl:    ttl_d = data_byte_i;
      PhSeq:    seq_d[8*lane[0] +: 8] = data_byte_i;
      PhGraph:  graph_d[8*lane[0] +: 8] = data_byte_i;
      PhDst:    dst_d[8*lane +: 8] = data_byte_i;
      PhSrc:    src_d[8*lane +: 8] = data_byte_i;
      PhPdu:    pdu_d = data_byte_i;
      PhProxy:  proxy_d[8*lane[0] +: 8] = data_byte_i;
      PhSecond: second_d[8*lane[0] +: 8] = data_byte_i;
      PhFirst:  first_d[8*lane[0] +: 8] = data_byte_i;
      default: ;
    endcase
  end

  always_comb begin
    case (ph_eff)
      PhSeq, PhGraph, PhProxy, PhSecond, PhFirst: flen = 4'd2;
      PhDst:   flen = ctl_d[DstModeBit] ? 4'd8 : 4'd2;
      PhSrc:   flen = ctl_d[SrcModeBit] ? 4'd8 : 4'd2;
      default: flen = 4'd1;
    endcase
  end

  assign field_done = (fbc_inc >= flen);

  always_comb begin
    case (ph_eff)
      PhCtl:   ph_next = PhTtl;
      PhTtl:   ph_next = PhSeq;
      PhSeq:   ph_next = PhGraph;
      PhGraph: ph_next = PhDst;
      PhDst:   ph_next = PhSrc;
      PhSrc:   ph_next = PhPdu;
      PhPdu:   ph_next = ctl_d[ProxyBit]  ? PhProxy  :
                         ctl_d[SecondBit] ? PhSecond :
                         ctl_d[FirstBit]  ? PhFirst  : PhPayload;
      PhProxy: ph_next = ctl_d[SecondBit] ? PhSecond :
                         ctl_d[FirstBit]  ? PhFirst  : PhPayload;
      PhSecond: ph_next = ctl_d[FirstBit] ? PhFirst : PhPayload;
      default: ph_next = PhPayload;
    endcase
  end

  assign complete = parsing & field_done & (ph_next == PhPayload);
  assign result   = parsing & (complete | end_flag_i);
  assign age      = now_slot_i - seq_d;

  always_comb begin
    if (!complete) begin
      res_stat = StatTruncated;
    end else if (ttl_d == 8'd0) begin
      res_stat = StatTtlZero;
    end else if (age > max_age_q) begin
      res_stat = StatExpired;
    end else begin
      res_stat = StatAccepted;
    end
  end

  always_comb begin
    phase_d = ph_eff;
    fbc_d   = fbc_eff;
    cons_d  = cons_eff;
    if (parsing) begin
      cons_d = cons_eff + LenW'(1);
      if (field_done) begin
        fbc_d   = '0;
        phase_d = ph_next;
      end else begin
        fbc_d = fbc_inc[CountW-1:0];
      end
    end
    if (end_flag_i) begin
      phase_d = PhCtl;
      fbc_d   = '0;
      cons_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q   <= MaxAgeReset;
      phase_q     <= PhCtl;
      fbc_q       <= '0;
      cons_q      <= '0;
      ctl_q       <= '0;
      ttl_q       <= '0;
      seq_q       <= '0;
      graph_q     <= '0;
      dst_q       <= '0;
      src_q       <= '0;
      pdu_q       <= '0;
      proxy_q     <= '0;
      second_q    <= '0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_age_q <= cfg_max_age_i;
      end
      if (accept) begin
        phase_q  <= phase_d;
        fbc_q    <= fbc_d;
        cons_q   <= cons_d;
        ctl_q    <= ctl_d;
        ttl_q    <= ttl_d;
        seq_q    <= seq_d;
        graph_q  <= graph_d;
        dst_q    <= dst_d;
        src_q    <= src_d;
        pdu_q    <= pdu_d;
        proxy_q  <= proxy_d;
        second_q <= second_d;
        first_q  <= first_d;
      end
      out_valid_q <= (accept & result) | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && result) begin
      o_ctl_q    <= ctl_d;
      o_ttl_q    <= ttl_d;
      o_seq_q    <= seq_d;
      o_graph_q  <= graph_d;
      o_dst_q    <= dst_d;
      o_src_q    <= src_d;
      o_pdu_q    <= pdu_d;
      o_proxy_q  <= proxy_d;
      o_second_q <= second_d;
      o_first_q  <= first_d;
      o_len_q    <= cons_eff + LenW'(1);
      o_stat_q   <= res_stat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign control_bits_o = o_ctl_q;
  assign hop_limit_o    = o_ttl_q;
  assign sequence_res_o = o_seq_q;
  assign graph_id_o     = o_graph_q;
  assign dest_addr_o    = o_dst_q;
  assign src_addr_o     = o_src_q;
  assign pdu_type_o     = o_pdu_q;
  assign proxy_addr_o   = o_proxy_q;
  assign second_addr_o  = o_second_q;
  assign first_addr_o   = o_first_q;
  assign hdr_len_o      = o_len_q;
  assign status_o       = o_stat_q;

endmodule
